// ===== hw/rtl/sba_pkg.sv =====
package sba_pkg;

   // default geometry
   localparam int SLOTS_DEF     = 4096;
   localparam int WORD_BITS_DEF = 64;

   // field widths
   localparam int ACTION_W = 2;
   localparam int IDX_W    = 12;

   // operation codes
   localparam logic [ACTION_W-1:0] ACT_FILL = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TEST = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_FIND = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic latch_req;   // capture slot index and mark value, clear results
      logic clear_addr;  // restart the word walk at word 0
      logic fill_wr;     // write all ones at the walk address, step
      logic div_step;    // word number of the slot index
      logic rem_step;    // bit number inside the word
      logic word_rd;     // read the addressed word
      logic word_wr;     // write back the marked word
      logic scan_rd;     // read the next word of the walk
      logic res_test;    // capture the test result
      logic res_find;    // capture the find result
      logic out_load;    // move the result to the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic fill_last;   // walk address is the last word
      logic hit;         // scanned word holds a free slot
      logic scan_end;    // last word has been scanned
   } sts_type;

   // result fields
   typedef struct packed {
      logic             free_slot_used;
      logic             found;
      logic [IDX_W-1:0] free_slot;
   } res_type;

endpackage

// ===== hw/rtl/slot_bitmap_allocator_top.sv =====
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tuser: action; tdata: slot_index, mark_value
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: slot_used, found, free_slot
//
// Mark and test step through the states DIV, REM, RD and then MWR or TST; fill and
// find are set by the single-port walk over the bitmap memory, one word a cycle, find
// plus its registered read.
// Reset starts a fill sweep over all NWORDS words (64 by default); no request is taken
// until it ends. One transaction is in work at a time; a result waiting in the
// output register does not block the next request, only the next result.
module slot_bitmap_allocator_top
   import sba_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [11:0] slot_index, [12] mark_value
   input  logic [ACTION_W-1:0] req_tuser,   // [1:0] action
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata    // [0] slot_used, [1] found, [13:2] free_slot
);

   cmd_type     cmd;
   sts_type     sts;
   res_type     res;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic        out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   sba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .sts        (sts),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   sba_datapath #(
      .SLOTS     (SLOTS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_slot_index (req_tdata[IDX_W-1:0]),
      .req_mark_value (req_tdata[IDX_W]),
      .sts            (sts),
      .res            (res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {2'b00, res.free_slot, res.found, res.free_slot_used};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a load never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result overwritten before transfer");

   // find and test results never mix
   a_fields_apart: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> !rsp_tdata[0])
      else $error("result carries both found and slot_used");

   // a request is taken only while no result is being built
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !cmd.out_load)
      else $error("result loaded right after acceptance");

endmodule

// ===== hw/rtl/sba_ctrl.sv =====
module sba_ctrl
   import sba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  sts_type             sts,
   input  logic                out_free,
   output cmd_type             cmd
);

   localparam logic [3:0] ST_INIT = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_FILL = 4'd2;
   localparam logic [3:0] ST_DIV  = 4'd3;
   localparam logic [3:0] ST_REM  = 4'd4;
   localparam logic [3:0] ST_RD   = 4'd5;
   localparam logic [3:0] ST_MWR  = 4'd6;
   localparam logic [3:0] ST_TST  = 4'd7;
   localparam logic [3:0] ST_SCAN = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [ACTION_W-1:0] act_ff, act_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in         = req_action;
               cmd.latch_req  = 1'b1;
               cmd.clear_addr = 1'b1;
               case (req_action)
                  ACT_FILL: state_in = ST_FILL;
                  ACT_FIND: state_in = ST_SCAN;
                  default:  state_in = ST_DIV;
               endcase
            end
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) state_in = ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_REM;
         end
         ST_REM: begin
            cmd.rem_step = 1'b1;
            state_in     = ST_RD;
         end
         ST_RD: begin
            cmd.word_rd = 1'b1;
            state_in    = (act_ff == ACT_MARK) ? ST_MWR : ST_TST;
         end
         ST_MWR: begin
            cmd.word_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_TST: begin
            cmd.res_test = 1'b1;
            state_in     = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.hit) begin
               cmd.res_find = 1'b1;
               state_in     = ST_DONE;
            end else if (sts.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         act_ff   <= ACT_FILL;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
      end
   end

   // a result is only handed over once the operation has finished
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == ST_IDLE))
      else $error("result load did not return to idle");

   // a scan stops at the first hit
   a_hit_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.res_find |=> !cmd.scan_rd)
      else $error("scan continued after a hit");

   // the init sweep never takes a transaction
   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !cmd.latch_req)
      else $error("transaction taken during init sweep");

endmodule

// ===== hw/rtl/sba_datapath.sv =====
module sba_datapath
   import sba_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] req_slot_index,
   input  logic             req_mark_value,
   output sts_type          sts,
   output res_type          res
);

   localparam int NWORDS    = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int BASE_W    = $clog2(SLOTS + 1);
   localparam int LAST_BITS = SLOTS - (NWORDS - 1) * WORD_BITS;
   localparam logic [WORD_AW-1:0] LAST_ADDR = WORD_AW'(NWORDS - 1);
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
   // reciprocal for the word number: exact for every 12-bit index
   localparam int RSH     = 19;
   localparam int RECIP   = ((1 << RSH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W  = IDX_W + 17;
   localparam int CMP_W   = 18;

   // bitmap memory
   logic [WORD_BITS-1:0] mem [NWORDS];

   logic [WORD_AW-1:0]   addr_ff;
   logic [BASE_W-1:0]    base_ff;
   logic                 live_ff;
   logic                 rvalid_ff;
   logic                 rlast_ff;
   logic [BASE_W-1:0]    rbase_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 mark_ff;
   logic                 oor_ff;
   logic [IDX_W-1:0]     quo_ff, quo_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   res_type              res_ff;

   logic [PROD_W-1:0]    prod;
   logic [IDX_W-1:0]     rem;
   logic [WORD_AW-1:0]   word_addr;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] marked_word;
   logic [WORD_BITS-1:0] free_bits;
   logic [BIT_W-1:0]     free_bit;
   logic [BASE_W:0]      hit_slot;
   logic                 at_last;
   logic                 mem_we, mem_re;
   logic [WORD_AW-1:0]   mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata;

   // lowest set bit of a word
   function automatic logic [BIT_W-1:0] low_index(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

   // slot index split into word and bit
   assign prod      = PROD_W'(idx_ff) * PROD_W'(RECIP);
   assign quo_in    = IDX_W'(prod >> RSH);
   assign rem       = idx_ff - IDX_W'(quo_ff * WORD_BITS);
   assign bit_in    = BIT_W'(rem);
   assign word_addr = WORD_AW'(quo_ff);

   // read-modify-write of one bit
   assign bit_mask    = WORD_BITS'(1) << bit_ff;
   assign marked_word = mark_ff ? (rdata_ff | bit_mask) : (rdata_ff & ~bit_mask);

   // scan of the word read in the previous cycle
   assign free_bits = ~rdata_ff & (rlast_ff ? LAST_MASK : {WORD_BITS{1'b1}});
   assign free_bit  = low_index(free_bits);
   assign hit_slot  = {1'b0, rbase_ff} + (BASE_W + 1)'(free_bit);
   assign at_last   = (addr_ff == LAST_ADDR);

   assign sts.fill_last = at_last;
   assign sts.hit       = rvalid_ff && (free_bits != '0);
   assign sts.scan_end  = rvalid_ff && rlast_ff;

   // memory port
   assign mem_we    = cmd.fill_wr || (cmd.word_wr && !oor_ff);
   assign mem_waddr = cmd.fill_wr ? addr_ff : word_addr;
   assign mem_wdata = cmd.fill_wr ? {WORD_BITS{1'b1}} : marked_word;
   assign mem_re    = cmd.word_rd || (cmd.scan_rd && live_ff);
   assign mem_raddr = cmd.word_rd ? word_addr : addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   // word walk for fill and find
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         base_ff   <= '0;
         live_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= cmd.scan_rd && live_ff;
         if (cmd.clear_addr) begin
            addr_ff <= '0;
            base_ff <= '0;
            live_ff <= 1'b1;
         end else if (cmd.fill_wr) begin
            addr_ff <= addr_ff + WORD_AW'(1);
         end else if (cmd.scan_rd && live_ff) begin
            addr_ff <= addr_ff + WORD_AW'(1);
            base_ff <= base_ff + BASE_W'(WORD_BITS);
            if (at_last) live_ff <= 1'b0;
         end
      end
   end

   // tags of the word in flight
   always_ff @(posedge clock) begin
      if (cmd.scan_rd && live_ff) begin
         rlast_ff <= at_last;
         rbase_ff <= base_ff;
      end
   end

   // request fields and index decode
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         idx_ff  <= req_slot_index;
         mark_ff <= req_mark_value;
         oor_ff  <= (CMP_W'(req_slot_index) >= CMP_W'(SLOTS));
      end
      if (cmd.div_step) quo_ff <= quo_in;
      if (cmd.rem_step) bit_ff <= bit_in;
   end

   // result fields
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         res_ff <= '0;
      end else if (cmd.res_test) begin
         res_ff.free_slot_used <= oor_ff ? 1'b1 : rdata_ff[bit_ff];
      end else if (cmd.res_find) begin
         res_ff.found     <= 1'b1;
         res_ff.free_slot <= IDX_W'(hit_slot);
      end
   end

   assign res = res_ff;

   // one memory access per cycle
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.fill_wr, cmd.word_wr, cmd.word_rd, cmd.scan_rd}))
      else $error("memory port accessed twice in a cycle");

   // a free slot found lies inside the bitmap
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      sts.hit |-> (hit_slot < (BASE_W + 1)'(SLOTS)))
      else $error("free slot beyond slot count");

   // a hit is captured as found on the next edge
   a_find_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.res_find |=> res_ff.found)
      else $error("find result not captured");

endmodule
